@@ rtl/core/blwm_pkg.sv @@
// ----------------------------------------------------------------------------
// blwm_pkg: shared types and constants of the byte lane word memory
// Command and size codes, request/response structs, lane helper functions.
// ----------------------------------------------------------------------------
package blwm_pkg;

    localparam int WORD_COUNT = 4096;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    localparam int ADDR_W      = 15;
    localparam int WORD_IDX_W  = ADDR_W - 3;
    localparam int DATA_W      = 64;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] SIZE_1B = 2'd0;
    localparam logic [1:0] SIZE_2B = 2'd1;
    localparam logic [1:0] SIZE_4B = 2'd2;
    localparam logic [1:0] SIZE_8B = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [1:0]        access_size;
        logic [ADDR_W-1:0] byte_address;
        logic [DATA_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              alignment_fault;
    } rsp_t;

    function automatic logic [DATA_W-1:0] lane_mask(input logic [1:0] size);
        logic [DATA_W-1:0] m;
        begin
            case (size)
                SIZE_1B: m = 64'h0000_0000_0000_00ff;
                SIZE_2B: m = 64'h0000_0000_0000_ffff;
                SIZE_4B: m = 64'h0000_0000_ffff_ffff;
                default: m = 64'hffff_ffff_ffff_ffff;
            endcase
            return m;
        end
    endfunction

    function automatic logic [2:0] align_mask(input logic [1:0] size);
        logic [2:0] m;
        begin
            case (size)
                SIZE_1B: m = 3'b000;
                SIZE_2B: m = 3'b001;
                SIZE_4B: m = 3'b011;
                default: m = 3'b111;
            endcase
            return m;
        end
    endfunction

endpackage

@@ rtl/core/byte_lane_word_memory.sv @@
// ----------------------------------------------------------------------------
// byte_lane_word_memory: byte-addressed memory of 64-bit words
// Reads, writes and whole-memory clears with byte lane select and merge.
// ----------------------------------------------------------------------------
// One request is handled at a time against a single-port synchronous word RAM
// with a registered read. An aligned, in-range read or write issues the RAM read
// on transfer, shifts or merges the lanes and writes back in ST_ACCESS, then loads
// the response register in ST_DONE once the response slot is free. A fault, an
// out-of-range word or an unused command goes straight to ST_DONE. A clear writes
// data_in to every word, one word per cycle, before it goes to ST_DONE.
// After reset the block sweeps zeros through every RAM word and holds req_ready
// low until the sweep is done. The response register lets the next request
// transfer while a response still waits.
module byte_lane_word_memory
    import blwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ACCESS,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    req_t                 cur_reg, cur_next;
    logic [WORD_AW-1:0]   pos_reg, pos_next;
    rsp_t                 res_reg, res_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [DATA_W-1:0]    mem [0:WORD_COUNT-1];
    logic [DATA_W-1:0]    mem_rdata;
    logic                 mem_re;
    logic                 mem_we;
    logic [WORD_AW-1:0]   mem_raddr;
    logic [WORD_AW-1:0]   mem_waddr;
    logic [DATA_W-1:0]    mem_wdata;

    logic                 req_fire;
    logic                 req_fault;
    logic                 req_in_range;
    logic                 req_is_access;
    logic [WORD_IDX_W-1:0] req_word;
    logic                 sweep_last;
    logic                 slot_free;

    logic [5:0]           cur_shift;
    logic [DATA_W-1:0]    cur_mask;
    logic [DATA_W-1:0]    rd_value;
    logic [DATA_W-1:0]    wr_value;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    assign req_word      = req.byte_address[ADDR_W-1:3];
    assign req_fault     = (req.byte_address[2:0] & align_mask(req.access_size)) != 3'b000;
    assign req_in_range  = 32'(req_word) < 32'(WORD_COUNT);
    assign req_is_access = (req.command == CMD_READ) || (req.command == CMD_WRITE);
    assign sweep_last    = (pos_reg == WORD_AW'(WORD_COUNT - 1));

    // lane select and merge on the word read back from the RAM
    assign cur_shift = {cur_reg.byte_address[2:0], 3'b000};
    assign cur_mask  = lane_mask(cur_reg.access_size);
    assign rd_value  = (mem_rdata >> cur_shift) & cur_mask;
    assign wr_value  = (mem_rdata & ~(cur_mask << cur_shift))
                     | ((cur_reg.data_in & cur_mask) << cur_shift);

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = WORD_AW'(req_word);
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = cur_reg.data_in;
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            ST_IDLE:
            begin
                mem_re = req_fire && req_is_access && !req_fault && req_in_range;
            end
            ST_ACCESS:
            begin
                mem_we    = (cur_reg.command == CMD_WRITE);
                mem_waddr = WORD_AW'(cur_reg.byte_address[ADDR_W-1:3]);
                mem_wdata = wr_value;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                pos_next = pos_reg + WORD_AW'(1);
                if (sweep_last)
                begin
                    pos_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    cur_next = req;
                    res_next = '0;
                    if (req.command == CMD_CLEAR)
                    begin
                        pos_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else if (req_is_access && req_fault)
                    begin
                        res_next.alignment_fault = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (req_is_access && req_in_range)
                    begin
                        state_next = ST_ACCESS;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ACCESS:
            begin
                if (cur_reg.command == CMD_READ)
                begin
                    res_next.read_data = rd_value;
                end
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                pos_next = pos_reg + WORD_AW'(1);
                if (sweep_last)
                begin
                    pos_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            pos_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            cur_reg       <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            rsp_valid_reg <= rsp_valid_next;
            cur_reg       <= cur_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[mem_raddr];
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the byte lane word memory
// Drives reads, writes, clears and idle commands through the request channel,
// predicts every response from a shadow copy of the word memory and checks
// each response field by field. Both channels see random idle gaps.
// ----------------------------------------------------------------------------
module tb_top;
    import blwm_pkg::*;

    localparam logic [1:0] CMD_NONE     = 2'd3;   // unused code, answers zero
    localparam int         RANDOM_ITEMS = 550;
    localparam int         MAX_CLEARS   = 6;      // each clear walks every word
    localparam int         CYCLE_LIMIT  = 400_000;
    localparam int         TAIL_CYCLES  = 20;

    // Shadow memory and queue of responses still owed by the block.
    class mem_scoreboard;
        logic [DATA_W-1:0] words [WORD_COUNT];
        rsp_t              expected_q [$];
        int                mismatches;
        int                checked;
        int                reads, writes, faults, clears, idle_cmds;

        function new();
            foreach (words[i])
                words[i] = '0;
            mismatches = 0;
            checked    = 0;
            reads      = 0;
            writes     = 0;
            faults     = 0;
            clears     = 0;
            idle_cmds  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(input req_t r);
            rsp_t              e;
            int unsigned       span;
            int unsigned       shift;
            int unsigned       idx;
            logic [DATA_W-1:0] lanes;
            e     = '0;
            span  = 1 << r.access_size;
            lanes = (span == 8) ? '1 : ((64'd1 << (span * 8)) - 64'd1);
            shift = r.byte_address[2:0] * 8;
            idx   = r.byte_address >> 3;
            if (r.command == CMD_CLEAR)
            begin
                foreach (words[i])
                    words[i] = r.data_in;
                clears++;
            end
            else if (r.command == CMD_READ || r.command == CMD_WRITE)
            begin
                // alignment is checked before the word range
                if (r.byte_address % span != 0)
                begin
                    e.alignment_fault = 1'b1;
                    faults++;
                end
                else if (idx < WORD_COUNT)
                begin
                    if (r.command == CMD_READ)
                    begin
                        e.read_data = (words[idx] >> shift) & lanes;
                        reads++;
                    end
                    else
                    begin
                        words[idx] = (words[idx] & ~(lanes << shift))
                                   | ((r.data_in & lanes) << shift);
                        writes++;
                    end
                end
            end
            else
            begin
                idle_cmds++;
            end
            expected_q.push_back(e);
        endfunction

        function void check_response(input rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("response with no request outstanding: read_data %h alignment_fault %b",
                       got.read_data, got.alignment_fault);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.read_data !== e.read_data)
            begin
                $error("read_data mismatch: expected %h, got %h", e.read_data, got.read_data);
                mismatches++;
            end
            if (got.alignment_fault !== e.alignment_fault)
            begin
                $error("alignment_fault mismatch: expected %b, got %b",
                       e.alignment_fault, got.alignment_fault);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    mem_scoreboard sb = new();
    bit            steady = 1'b0;   // no idling on either side while set
    int            clears_issued = 0;
    int            cycle_count = 0;

    byte_lane_word_memory dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic req_t make_req(input logic [1:0] cmd, input logic [1:0] size,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [DATA_W-1:0] data);
        req_t r;
        r.command      = cmd;
        r.access_size  = size;
        r.byte_address = addr;
        r.data_in      = data;
        return r;
    endfunction

    function automatic req_t next_random_request();
        req_t        r;
        int unsigned pick;
        int unsigned span;
        int unsigned word;
        int unsigned offset;
        pick = $urandom_range(0, 99);
        if (pick < 2 && clears_issued < MAX_CLEARS)
        begin
            r.command = CMD_CLEAR;
            clears_issued++;
        end
        else if (pick < 5)
            r.command = CMD_NONE;
        else if (pick < 52)
            r.command = CMD_WRITE;
        else
            r.command = CMD_READ;
        r.access_size = 2'($urandom_range(0, 3));
        span = 1 << r.access_size;
        // keep most traffic on a few words at both ends so reads see earlier writes
        if ($urandom_range(0, 3) != 0)
        begin
            word = $urandom_range(0, 15);
            if (word >= 8)
                word = WORD_COUNT - 16 + word;
        end
        else
            word = $urandom_range(0, WORD_COUNT - 1);
        offset = $urandom_range(0, 7);
        if ($urandom_range(0, 6) != 0)
            offset = offset & ~(span - 1);
        r.byte_address = ADDR_W'(word * 8 + offset);
        r.data_in = {$urandom(), $urandom()};
        if ($urandom_range(0, 15) == 0)
            r.data_in = $urandom_range(0, 1) ? '1 : '0;
        return r;
    endfunction

    task automatic issue(input req_t item);
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat (idle_cycles()) @(posedge clk);
        end
    endtask

    // hold off until every owed response is back
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, sb.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // response side back-pressure
    initial
    begin
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!steady && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat (idle_cycles()) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        req_t directed_q [$];
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_q.push_back(make_req(CMD_READ,  SIZE_8B, 15'h0000, 64'h0));
        directed_q.push_back(make_req(CMD_WRITE, SIZE_8B, 15'h0000, '1));
        directed_q.push_back(make_req(CMD_READ,  SIZE_1B, 15'h0007, 64'h0));
        // upper bytes of the write value must be dropped
        directed_q.push_back(make_req(CMD_WRITE, SIZE_1B, 15'h0003, 64'hffff_ffff_ffff_ff00));
        directed_q.push_back(make_req(CMD_READ,  SIZE_8B, 15'h0000, 64'h0));
        directed_q.push_back(make_req(CMD_WRITE, SIZE_2B, 15'h0006, 64'h5555_aaaa_0000_1234));
        directed_q.push_back(make_req(CMD_READ,  SIZE_2B, 15'h0006, 64'h0));
        directed_q.push_back(make_req(CMD_WRITE, SIZE_4B, 15'h0004, 64'h1111_2222_dead_beef));
        directed_q.push_back(make_req(CMD_READ,  SIZE_4B, 15'h0004, 64'h0));
        // misaligned: fault, no memory change
        directed_q.push_back(make_req(CMD_WRITE, SIZE_2B, 15'h0001, 64'h0));
        directed_q.push_back(make_req(CMD_READ,  SIZE_4B, 15'h0002, 64'h0));
        directed_q.push_back(make_req(CMD_READ,  SIZE_8B, 15'h0004, 64'h0));
        directed_q.push_back(make_req(CMD_READ,  SIZE_8B, 15'h0000, 64'h0));
        directed_q.push_back(make_req(CMD_WRITE, SIZE_8B, 15'h7ff8, 64'h8000_0000_0000_0001));
        directed_q.push_back(make_req(CMD_READ,  SIZE_1B, 15'h7fff, 64'h0));
        directed_q.push_back(make_req(CMD_READ,  SIZE_8B, 15'h7ff8, 64'h0));
        directed_q.push_back(make_req(CMD_NONE,  SIZE_8B, 15'h7fff, '1));
        // clear ignores size and address, so a misaligned pair must not fault
        directed_q.push_back(make_req(CMD_CLEAR, SIZE_2B, 15'h0001, 64'ha5a5_5a5a_c3c3_3c3c));
        directed_q.push_back(make_req(CMD_READ,  SIZE_8B, 15'h4000, 64'h0));
        directed_q.push_back(make_req(CMD_READ,  SIZE_1B, 15'h7ffe, 64'h0));
        directed_q.push_back(make_req(CMD_CLEAR, SIZE_8B, 15'h7fff, 64'h0));
        directed_q.push_back(make_req(CMD_READ,  SIZE_8B, 15'h7ff8, 64'h0));
        clears_issued = 2;
        foreach (directed_q[i])
            issue(directed_q[i]);
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 100 && n < 160);
            if (n == RANDOM_ITEMS / 2)
                drain();
            issue(next_random_request());
        end
        steady = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Checked %0d responses: %0d reads, %0d writes, %0d misaligned accesses,",
                 sb.checked, sb.reads, sb.writes, sb.faults);
        $display("%0d whole-memory clears and %0d unused commands, under random stalls",
                 sb.clears, sb.idle_cmds);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ byte_lane_word_memory.f @@
rtl/core/blwm_pkg.sv
rtl/core/byte_lane_word_memory.sv
sim/tb_top.sv
